// File: hdl/assert_macros.svh
// Assertion helpers shared by the RTL; every check runs on i_clk and is off in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that expr holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Check that cons holds in the same cycle whenever ante holds.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: hdl/tgcc_pkg.sv
package tgcc_pkg;

    localparam int WORD_BITS      = 32;
    localparam int CMD_FIELD_BITS = 3;
    localparam int REPEAT_BITS    = WORD_BITS - CMD_FIELD_BITS;
    localparam int EXTENT_BITS    = 31;
    localparam int REASON_BITS    = 3;
    localparam int KIND_BITS      = 3;
    localparam int ADDR_BITS      = 3;
    localparam int DATA_BITS      = 32;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // input opcodes
    localparam logic [1:0] OP_BEGIN = 2'd0;
    localparam logic [1:0] OP_GEOM  = 2'd1;
    localparam logic [1:0] OP_END   = 2'd2;

    // saturated feature counts
    localparam logic [1:0] FC_NONE = 2'd0;
    localparam logic [1:0] FC_ONE  = 2'd1;

    // geometry commands
    localparam logic [CMD_FIELD_BITS-1:0] CMD_MOVE_TO = 3'd1;
    localparam logic [CMD_FIELD_BITS-1:0] CMD_LINE_TO = 3'd2;

    // classified transaction kinds
    localparam logic [KIND_BITS-1:0] K_BEGIN_NONE = 3'd0;
    localparam logic [KIND_BITS-1:0] K_BEGIN_MANY = 3'd1;
    localparam logic [KIND_BITS-1:0] K_BEGIN_ONE  = 3'd2;
    localparam logic [KIND_BITS-1:0] K_GEOM       = 3'd3;
    localparam logic [KIND_BITS-1:0] K_END        = 3'd4;

    // verdict reasons
    localparam logic [REASON_BITS-1:0] R_NO_FEATURES = 3'd0;
    localparam logic [REASON_BITS-1:0] R_MANY        = 3'd1;
    localparam logic [REASON_BITS-1:0] R_OVERFLOW    = 3'd2;
    localparam logic [REASON_BITS-1:0] R_INSIDE      = 3'd3;
    localparam logic [REASON_BITS-1:0] R_COVERS      = 3'd4;

    // register map
    localparam logic REG_EXTENT = 1'b0;
    localparam logic [EXTENT_BITS-1:0] EXTENT_RESET = 31'd4096;

    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        logic [WORD_BITS-1:0] word;
    } t_q_item;

    typedef struct packed {
        logic valid;
        logic full;
    } t_q_status;

endpackage

// File: hdl/tgcc_front.sv
module tgcc_front (
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_opcode,
    input  logic [1:0]                   i_feature_count,
    input  logic [tgcc_pkg::WORD_BITS-1:0] i_geometry_word,
    input  tgcc_pkg::t_q_status          i_q_status,
    output logic                         o_push,
    output tgcc_pkg::t_q_item            o_item
);

    logic w_keep;

    always_comb begin
        w_keep      = 1'b1;
        o_item.word = i_geometry_word;
        o_item.kind = tgcc_pkg::K_GEOM;
        unique case (i_opcode)
            tgcc_pkg::OP_BEGIN: begin
                unique case (i_feature_count)
                    tgcc_pkg::FC_NONE: o_item.kind = tgcc_pkg::K_BEGIN_NONE;
                    tgcc_pkg::FC_ONE:  o_item.kind = tgcc_pkg::K_BEGIN_ONE;
                    default:           o_item.kind = tgcc_pkg::K_BEGIN_MANY;
                endcase
            end
            tgcc_pkg::OP_GEOM: o_item.kind = tgcc_pkg::K_GEOM;
            tgcc_pkg::OP_END:  o_item.kind = tgcc_pkg::K_END;
            // unused opcode: accept and drop
            default:           w_keep = 1'b0;
        endcase
    end

    assign o_in_ready = !i_q_status.full;
    assign o_push     = i_in_valid && !i_q_status.full && w_keep;

endmodule

// File: hdl/tgcc_queue.sv
module tgcc_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  tgcc_pkg::t_q_item   i_item,
    input  logic                i_pop,
    output tgcc_pkg::t_q_status o_status,
    output tgcc_pkg::t_q_item   o_item
);

    tgcc_pkg::t_q_item r_slot [tgcc_pkg::QUEUE_DEPTH];
    logic [tgcc_pkg::QPTR_BITS-1:0] r_wr_ptr;
    logic [tgcc_pkg::QPTR_BITS-1:0] r_rd_ptr;
    logic [tgcc_pkg::QCNT_BITS-1:0] r_count;
    logic [tgcc_pkg::QCNT_BITS-1:0] n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + tgcc_pkg::QCNT_BITS'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - tgcc_pkg::QCNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + tgcc_pkg::QPTR_BITS'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + tgcc_pkg::QPTR_BITS'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

    assign o_item          = r_slot[r_rd_ptr];
    assign o_status.valid  = (r_count != '0);
    assign o_status.full   = (r_count == tgcc_pkg::QCNT_BITS'(tgcc_pkg::QUEUE_DEPTH));

endmodule

// File: hdl/tgcc_back.sv
module tgcc_back #(
    parameter int COORD_BITS = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [tgcc_pkg::EXTENT_BITS-1:0]     i_extent,
    input  logic                                 i_q_valid,
    input  tgcc_pkg::t_q_item                    i_q_item,
    output logic                                 o_pop,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic                                 o_interesting,
    output logic [tgcc_pkg::REASON_BITS-1:0]     o_verdict_reason
);

    localparam int CMP_BITS = (COORD_BITS > tgcc_pkg::EXTENT_BITS) ?
                              COORD_BITS : tgcc_pkg::EXTENT_BITS;

    function automatic logic [COORD_BITS-1:0] unzig(input logic [tgcc_pkg::WORD_BITS-1:0] w);
        logic [tgcc_pkg::WORD_BITS-1:0]   d;
        logic [2*tgcc_pkg::WORD_BITS-1:0] ext;
        d   = (w >> 1) ^ {tgcc_pkg::WORD_BITS{w[0]}};
        ext = {{tgcc_pkg::WORD_BITS{d[tgcc_pkg::WORD_BITS-1]}}, d};
        return ext[COORD_BITS-1:0];
    endfunction

    function automatic logic inside_extent(input logic [COORD_BITS-1:0] v,
                                           input logic [tgcc_pkg::EXTENT_BITS-1:0] e);
        return !v[COORD_BITS-1] && (v != '0) && (CMP_BITS'(v) < CMP_BITS'(e));
    endfunction

    // layer and decode state
    logic                               r_active,     n_active;
    logic [tgcc_pkg::REPEAT_BITS-1:0]   r_repeat,     n_repeat;
    logic                               r_await_dy,   n_await_dy;
    logic [tgcc_pkg::WORD_BITS-1:0]     r_pending_dx, n_pending_dx;
    logic [COORD_BITS-1:0]              r_cursor_x,   n_cursor_x;
    logic [COORD_BITS-1:0]              r_cursor_y,   n_cursor_y;
    logic [1:0][COORD_BITS-1:0]         r_x_vals,     n_x_vals;
    logic [1:0][COORD_BITS-1:0]         r_y_vals,     n_y_vals;
    logic [1:0]                         r_x_kept,     n_x_kept;
    logic [1:0]                         r_y_kept,     n_y_kept;
    logic                               r_x_over,     n_x_over;
    logic                               r_y_over,     n_y_over;

    // output stage
    logic                               r_out_valid;
    logic                               r_interesting;
    logic [tgcc_pkg::REASON_BITS-1:0]   r_reason;

    logic                               w_has_result;
    logic                               w_interesting;
    logic [tgcc_pkg::REASON_BITS-1:0]   w_reason;
    logic                               w_inside;
    logic [COORD_BITS-1:0]              w_sum_x;
    logic [COORD_BITS-1:0]              w_sum_y;
    logic                               w_hit_x;
    logic                               w_hit_y;
    logic [tgcc_pkg::CMD_FIELD_BITS-1:0] w_cmd;

    assign w_sum_x = r_cursor_x + unzig(r_pending_dx);
    assign w_sum_y = r_cursor_y + unzig(i_q_item.word);
    assign w_hit_x = ((r_x_kept != 2'd0) && (r_x_vals[0] == w_sum_x)) ||
                     ((r_x_kept == 2'd2) && (r_x_vals[1] == w_sum_x));
    assign w_hit_y = ((r_y_kept != 2'd0) && (r_y_vals[0] == w_sum_y)) ||
                     ((r_y_kept == 2'd2) && (r_y_vals[1] == w_sum_y));
    assign w_cmd   = i_q_item.word[tgcc_pkg::CMD_FIELD_BITS-1:0];

    // verdict on the state built so far
    always_comb begin
        w_inside = 1'b0;
        for (int i = 0; i < 2; i++) begin
            if (r_x_kept > 2'(i) && inside_extent(r_x_vals[i], i_extent)) begin
                w_inside = 1'b1;
            end
            if (r_y_kept > 2'(i) && inside_extent(r_y_vals[i], i_extent)) begin
                w_inside = 1'b1;
            end
        end
    end

    always_comb begin
        w_has_result  = 1'b0;
        w_interesting = 1'b0;
        w_reason      = tgcc_pkg::R_COVERS;
        unique case (i_q_item.kind) inside
            tgcc_pkg::K_BEGIN_NONE: begin
                w_has_result = 1'b1;
                w_reason     = tgcc_pkg::R_NO_FEATURES;
            end
            tgcc_pkg::K_BEGIN_MANY: begin
                w_has_result  = 1'b1;
                w_interesting = 1'b1;
                w_reason      = tgcc_pkg::R_MANY;
            end
            tgcc_pkg::K_END: begin
                w_has_result = r_active;
                if (r_x_over || r_y_over) begin
                    w_interesting = 1'b1;
                    w_reason      = tgcc_pkg::R_OVERFLOW;
                end else if (w_inside) begin
                    w_interesting = 1'b1;
                    w_reason      = tgcc_pkg::R_INSIDE;
                end
            end
            default: w_has_result = 1'b0;
        endcase
    end

    // hold the queue while a result cannot be placed
    assign o_pop = i_q_valid && (!w_has_result || !r_out_valid || i_out_ready);

    always_comb begin
        n_active     = r_active;
        n_repeat     = r_repeat;
        n_await_dy   = r_await_dy;
        n_pending_dx = r_pending_dx;
        n_cursor_x   = r_cursor_x;
        n_cursor_y   = r_cursor_y;
        n_x_vals     = r_x_vals;
        n_y_vals     = r_y_vals;
        n_x_kept     = r_x_kept;
        n_y_kept     = r_y_kept;
        n_x_over     = r_x_over;
        n_y_over     = r_y_over;
        if (o_pop) begin
            unique case (i_q_item.kind) inside
                tgcc_pkg::K_BEGIN_NONE, tgcc_pkg::K_BEGIN_MANY, tgcc_pkg::K_BEGIN_ONE,
                tgcc_pkg::K_END: begin
                    if (i_q_item.kind != tgcc_pkg::K_END || r_active) begin
                        n_active   = (i_q_item.kind == tgcc_pkg::K_BEGIN_ONE);
                        n_repeat   = '0;
                        n_await_dy = 1'b0;
                        n_cursor_x = '0;
                        n_cursor_y = '0;
                        n_x_kept   = 2'd0;
                        n_y_kept   = 2'd0;
                        n_x_over   = 1'b0;
                        n_y_over   = 1'b0;
                    end
                end
                tgcc_pkg::K_GEOM: begin
                    if (r_active) begin
                        if (r_repeat == '0) begin
                            n_await_dy = 1'b0;
                            if (w_cmd == tgcc_pkg::CMD_MOVE_TO ||
                                w_cmd == tgcc_pkg::CMD_LINE_TO) begin
                                n_repeat = i_q_item.word[tgcc_pkg::WORD_BITS-1:
                                                         tgcc_pkg::CMD_FIELD_BITS];
                            end else begin
                                n_repeat = '0;
                            end
                        end else if (!r_await_dy) begin
                            n_pending_dx = i_q_item.word;
                            n_await_dy   = 1'b1;
                        end else begin
                            n_cursor_x = w_sum_x;
                            n_cursor_y = w_sum_y;
                            n_await_dy = 1'b0;
                            n_repeat   = r_repeat - tgcc_pkg::REPEAT_BITS'(1);
                            if (!w_hit_x) begin
                                if (r_x_kept != 2'd2) begin
                                    n_x_vals[r_x_kept[0]] = w_sum_x;
                                    n_x_kept = r_x_kept + 2'd1;
                                end else begin
                                    n_x_over = 1'b1;
                                end
                            end
                            if (!w_hit_y) begin
                                if (r_y_kept != 2'd2) begin
                                    n_y_vals[r_y_kept[0]] = w_sum_y;
                                    n_y_kept = r_y_kept + 2'd1;
                                end else begin
                                    n_y_over = 1'b1;
                                end
                            end
                        end
                    end
                end
                default: n_active = r_active;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_repeat    <= '0;
            r_await_dy  <= 1'b0;
            r_cursor_x  <= '0;
            r_cursor_y  <= '0;
            r_x_kept    <= 2'd0;
            r_y_kept    <= 2'd0;
            r_x_over    <= 1'b0;
            r_y_over    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_active   <= n_active;
            r_repeat   <= n_repeat;
            r_await_dy <= n_await_dy;
            r_cursor_x <= n_cursor_x;
            r_cursor_y <= n_cursor_y;
            r_x_kept   <= n_x_kept;
            r_y_kept   <= n_y_kept;
            r_x_over   <= n_x_over;
            r_y_over   <= n_y_over;
            if (o_pop && w_has_result) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pending_dx <= n_pending_dx;
        r_x_vals     <= n_x_vals;
        r_y_vals     <= n_y_vals;
        if (o_pop && w_has_result) begin
            r_interesting <= w_interesting;
            r_reason      <= w_reason;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_interesting    = r_interesting;
    assign o_verdict_reason = r_reason;

endmodule

// File: hdl/tile_geometry_coverage_check.sv
// Tile geometry coverage check. Takes one transaction per clock while the queue has room:
// begin-layer items, geometry words and end-of-geometry items, and returns at most one
// verdict per item (interesting flag plus reason). A front stage classifies each
// transaction into a two-entry queue; the back stage pulls one entry per cycle unless a
// held output blocks it, updating the cursor with one COORD_BITS-wide add per axis and a
// compare against the two kept values per axis, so the sustained rate is one item per
// cycle. A verdict is loaded into the output register at the edge that takes its item
// from the queue; a held output stops the queue only while the entry at its head
// produces a verdict, and the input stalls once both queue entries are taken. The
// extent register sits at address 0 and should be written only while the block is
// idle. No clearing pass follows reset.
`include "assert_macros.svh"

module tile_geometry_coverage_check #(
    parameter int COORD_BITS = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [1:0]                           i_opcode,
    input  logic [1:0]                           i_feature_count,
    input  logic [tgcc_pkg::WORD_BITS-1:0]       i_geometry_word,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic                                 o_interesting,
    output logic [tgcc_pkg::REASON_BITS-1:0]     o_verdict_reason,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [tgcc_pkg::ADDR_BITS-1:0]       paddr,
    input  logic [tgcc_pkg::DATA_BITS-1:0]       pwdata,
    output logic [tgcc_pkg::DATA_BITS-1:0]       prdata,
    output logic                                 pready
);

    logic [tgcc_pkg::EXTENT_BITS-1:0] r_extent;
    tgcc_pkg::t_q_status              w_q_status;
    tgcc_pkg::t_q_item                w_push_item;
    tgcc_pkg::t_q_item                w_head_item;
    logic                             w_push;
    logic                             w_pop;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_extent <= tgcc_pkg::EXTENT_RESET;
        end else if (psel && penable && pwrite && paddr[2] == tgcc_pkg::REG_EXTENT) begin
            r_extent <= pwdata[tgcc_pkg::EXTENT_BITS-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == tgcc_pkg::REG_EXTENT) begin
            prdata = tgcc_pkg::DATA_BITS'(r_extent);
        end
    end

    tgcc_front u_front (
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_opcode        (i_opcode),
        .i_feature_count (i_feature_count),
        .i_geometry_word (i_geometry_word),
        .i_q_status      (w_q_status),
        .o_push          (w_push),
        .o_item          (w_push_item)
    );

    tgcc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_item   (w_push_item),
        .i_pop    (w_pop),
        .o_status (w_q_status),
        .o_item   (w_head_item)
    );

    tgcc_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_extent         (r_extent),
        .i_q_valid        (w_q_status.valid),
        .i_q_item         (w_head_item),
        .o_pop            (w_pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_interesting    (o_interesting),
        .o_verdict_reason (o_verdict_reason)
    );

    `ASSERT_IMPLIES(a_pop_needs_entry, w_pop, w_q_status.valid, "pop from empty queue")
    `ASSERT_IMPLIES(a_stall_only_when_full, !o_in_ready, w_q_status.valid,
                    "input stalled with empty queue")
    `ASSERT_IMPLIES(a_flag_matches_reason, o_out_valid,
                    o_interesting == (o_verdict_reason == tgcc_pkg::R_MANY ||
                                      o_verdict_reason == tgcc_pkg::R_OVERFLOW ||
                                      o_verdict_reason == tgcc_pkg::R_INSIDE),
                    "interesting flag disagrees with reason")

endmodule
